// ===== design/ibb_pkg.sv =====
package ibb_pkg;

	// Default sizes
	localparam int PAL_DEPTH_DEF    = 256;
	localparam int COORD_BITS_DEF   = 12;
	// Coordinates travel in the job queue at the widest supported size
	localparam int JOB_COORD_BITS   = 16;
	localparam int JOB_QUEUE_DEPTH  = 4;
	localparam int RES_QUEUE_DEPTH  = 4;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_PAL_WR = 2'd0,
		OP_ROW    = 2'd1,
		OP_DATA   = 2'd2,
		OP_NONE   = 2'd3
	} op_e;

	// Pixel modes
	localparam logic [2:0] MODE_1BPP  = 3'd0;
	localparam logic [2:0] MODE_2BPP  = 3'd1;
	localparam logic [2:0] MODE_4BPP  = 3'd2;
	localparam logic [2:0] MODE_8BPP  = 3'd3;
	localparam logic [2:0] MODE_24BPP = 3'd4;

	// Orientations
	localparam logic [1:0] ORIENT_0   = 2'd0;
	localparam logic [1:0] ORIENT_90  = 2'd1;
	localparam logic [1:0] ORIENT_180 = 2'd2;
	localparam logic [1:0] ORIENT_270 = 2'd3;

	// Register indexes
	localparam logic [2:0] REG_PIXEL_MODE  = 3'd0;
	localparam logic [2:0] REG_KEY_ENABLE  = 3'd1;
	localparam logic [2:0] REG_KEY_COLOR   = 3'd2;
	localparam logic [2:0] REG_FB_LEFT     = 3'd3;
	localparam logic [2:0] REG_FB_TOP      = 3'd4;
	localparam logic [2:0] REG_FB_WIDTH    = 3'd5;
	localparam logic [2:0] REG_FB_HEIGHT   = 3'd6;
	localparam logic [2:0] REG_ORIENTATION = 3'd7;

	typedef struct packed {
		logic [2:0]  pixel_mode;
		logic        key_enable;
		logic [23:0] key_color;
		logic [11:0] fb_left;
		logic [11:0] fb_top;
		logic [12:0] fb_width;
		logic [12:0] fb_height;
		logic [1:0]  orientation;
	} cfg_t;

	typedef struct packed {
		op_e         op;
		logic [7:0]  palette_index;
		logic [23:0] palette_color;
		logic [11:0] dest_x;
		logic [11:0] dest_y;
		logic [12:0] pixel_count;
		logic [2:0]  left_bit_offset;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic [23:0] pixel_offset;
		logic [23:0] color;
		logic        last;
	} res_t;

	typedef enum logic {
		JOB_WRITE = 1'b0,
		JOB_PIXEL = 1'b1
	} job_kind_e;

	// One entry of the queue between front and back
	typedef struct packed {
		job_kind_e                 kind;
		logic                      is_end;  // final pixel position of its transaction
		logic                      direct;  // color holds a direct 24-bit color
		logic [7:0]                index;   // palette index (lookup or write)
		logic [23:0]               color;
		logic [JOB_COORD_BITS-1:0] x;
		logic [JOB_COORD_BITS-1:0] y;
	} job_t;

endpackage

// ===== design/indexed_bitmap_blitter.sv =====
// Indexed bitmap blitter.
// Input channel: an item is taken when push is high and full is low. Palette
// writes and row starts produce no result; each data byte produces up to eight
// pixel results (1bpp), one (8bpp), or one for every third byte (24bpp BGR).
// Result channel: while empty is low the oldest result is on 'result'; pop
// takes it. 'last' marks the final result caused by one data byte.
// Configuration: cfg_we writes cfg_data into register cfg_index in the same
// cycle; write only while no transaction is in flight.
// Path: front register, job queue, stage 2, stage 3, result queue; a result
// whose later pixel positions in the same byte are keyed out waits for them.
// Throughput: one pixel position per cycle while the job queue has room, set by the front
// unpacker; an 8bpp or 24bpp stream takes one item per cycle, a 1bpp byte holds the input until unpacked.
// Palette writes pass through the same job queue as pixels, so a lookup
// always sees every palette write accepted before it.
// Reset clears control state and loads the register defaults; the palette is
// undefined until written. When pop is held low the result queue fills, the
// back end stalls, the job queue fills and full rises; nothing is dropped.
module indexed_bitmap_blitter import ibb_pkg::*; #(
	parameter int PALETTE_DEPTH = PAL_DEPTH_DEF,
	parameter int COORD_BITS    = COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        push,
	output logic        full,
	output res_t        result,
	output logic        empty,
	input  logic        pop,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	cfg_t cfg_q;
	job_t job_in;
	job_t job_head;
	logic job_push;
	logic job_pop;
	logic q_full;
	logic q_empty;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_mode  <= MODE_8BPP;
			cfg_q.key_enable  <= 1'b0;
			cfg_q.key_color   <= '0;
			cfg_q.fb_left     <= '0;
			cfg_q.fb_top      <= '0;
			cfg_q.fb_width    <= 13'd320;
			cfg_q.fb_height   <= 13'd240;
			cfg_q.orientation <= ORIENT_0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXEL_MODE:  cfg_q.pixel_mode  <= cfg_data[2:0];
				REG_KEY_ENABLE:  cfg_q.key_enable  <= cfg_data[0];
				REG_KEY_COLOR:   cfg_q.key_color   <= cfg_data;
				REG_FB_LEFT:     cfg_q.fb_left     <= cfg_data[11:0];
				REG_FB_TOP:      cfg_q.fb_top      <= cfg_data[11:0];
				REG_FB_WIDTH:    cfg_q.fb_width    <= cfg_data[12:0];
				REG_FB_HEIGHT:   cfg_q.fb_height   <= cfg_data[12:0];
				REG_ORIENTATION: cfg_q.orientation <= cfg_data[1:0];
			endcase
		end
	end

	// Front: accept, classify, unpack
	ibb_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.item     (item),
		.push     (push),
		.full     (full),
		.job      (job_in),
		.job_push (job_push),
		.q_full   (q_full)
	);

	// Job queue between front and back
	ibb_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (JOB_QUEUE_DEPTH)
	) u_job_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (q_full),
		.pop    (job_pop),
		.rdata  (job_head),
		.empty  (q_empty)
	);

	// Back: palette, key, address, result queue
	ibb_back #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (job_head),
		.job_avail (!q_empty),
		.job_pop   (job_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== design/ibb_fifo.sv =====
module ibb_fifo import ibb_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entries_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fifo fill count beyond depth");

endmodule

// ===== design/ibb_front.sv =====
module ibb_front import ibb_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  item_t item,
	input  logic  push,
	output logic  full,
	output job_t  job,
	output logic  job_push,
	input  logic  q_full
);

	// Held transaction
	item_t      item_s1;
	logic       valid_s1;
	logic       first_s1;
	logic [3:0] pos_s1;

	// Row state
	logic [COORD_BITS-1:0] cur_x_q;
	logic [COORD_BITS-1:0] cur_y_q;
	logic [12:0]           pixels_left_q;
	logic [2:0]            bit_pos_q;
	logic [15:0]           gather_q;
	logic [1:0]            gather_cnt_q;

	logic       accept;
	logic       done;
	logic       row_load;
	logic       px_step;
	logic       gather_add;
	logic       gather_clr;
	logic       bitpos_clr;
	logic       sub_adv;
	logic [4:0] p5;
	logic [4:0] bpp;
	logic       fits;
	logic       last_pix;
	logic [7:0] shifted;
	logic [7:0] sub_idx;

	assign full   = valid_s1 && !done;
	assign accept = push && !full;

	// Sub-byte unpacking position
	always_comb begin
		p5      = first_s1 ? {2'b00, bit_pos_q} : {1'b0, pos_s1};
		bpp     = 5'd1 << cfg.pixel_mode[1:0];
		fits    = (p5 + bpp) <= 5'd8;
		last_pix = (pixels_left_q == 13'd1) || ((p5 + (bpp << 1)) > 5'd8);
		shifted = 8'(item_s1.data_byte << p5[2:0]);
		unique case (cfg.pixel_mode[1:0])
			2'd0:    sub_idx = {7'b0, shifted[7]};
			2'd1:    sub_idx = {6'b0, shifted[7:6]};
			default: sub_idx = {4'b0, shifted[7:4]};
		endcase
	end

	// Classify the held transaction and produce at most one job per cycle while the job queue has room
	always_comb begin
		done       = 1'b0;
		job_push   = 1'b0;
		row_load   = 1'b0;
		px_step    = 1'b0;
		gather_add = 1'b0;
		gather_clr = 1'b0;
		bitpos_clr = 1'b0;
		sub_adv    = 1'b0;
		job.kind   = JOB_PIXEL;
		job.is_end = 1'b1;
		job.direct = 1'b0;
		job.index  = item_s1.data_byte;
		job.color  = {item_s1.data_byte, gather_q};
		job.x      = JOB_COORD_BITS'(cur_x_q);
		job.y      = JOB_COORD_BITS'(cur_y_q);
		if (valid_s1) begin
			unique case (item_s1.op)
				OP_PAL_WR: begin
					job.kind  = JOB_WRITE;
					job.index = item_s1.palette_index;
					job.color = item_s1.palette_color;
					if (!q_full) begin
						job_push = 1'b1;
						done     = 1'b1;
					end
				end
				OP_ROW: begin
					row_load = 1'b1;
					done     = 1'b1;
				end
				OP_DATA: begin
					priority if (pixels_left_q == '0 || cfg.pixel_mode > MODE_24BPP) begin
						done = 1'b1;
					end else if (cfg.pixel_mode == MODE_8BPP) begin
						if (!q_full) begin
							job_push = 1'b1;
							px_step  = 1'b1;
							done     = 1'b1;
						end
					end else if (cfg.pixel_mode == MODE_24BPP) begin
						job.direct = 1'b1;
						if (gather_cnt_q < 2'd2) begin
							gather_add = 1'b1;
							done       = 1'b1;
						end else if (!q_full) begin
							job_push   = 1'b1;
							px_step    = 1'b1;
							gather_clr = 1'b1;
							done       = 1'b1;
						end
					end else begin
						job.index  = sub_idx;
						job.is_end = last_pix;
						if (!fits) begin
							bitpos_clr = 1'b1;
							done       = 1'b1;
						end else if (!q_full) begin
							job_push = 1'b1;
							px_step  = 1'b1;
							if (last_pix) begin
								bitpos_clr = 1'b1;
								done       = 1'b1;
							end else begin
								sub_adv = 1'b1;
							end
						end
					end
				end
				OP_NONE: begin
					done = 1'b1;
				end
			endcase
		end
	end

	// Holding register for the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				first_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end else if (sub_adv) begin
				first_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (sub_adv) begin
			pos_s1 <= p5[3:0] + bpp[3:0];
		end
	end

	// Row state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			pixels_left_q <= '0;
			bit_pos_q     <= '0;
			gather_q      <= '0;
			gather_cnt_q  <= '0;
		end else begin
			if (row_load) begin
				cur_x_q       <= COORD_BITS'(item_s1.dest_x);
				cur_y_q       <= COORD_BITS'(item_s1.dest_y);
				pixels_left_q <= item_s1.pixel_count;
				bit_pos_q     <= item_s1.left_bit_offset;
				gather_q      <= '0;
				gather_cnt_q  <= '0;
			end
			if (px_step) begin
				cur_x_q       <= cur_x_q + 1'b1;
				pixels_left_q <= pixels_left_q - 1'b1;
			end
			if (gather_add) begin
				if (gather_cnt_q == 2'd0) begin
					gather_q[7:0] <= item_s1.data_byte;
				end else begin
					gather_q[15:8] <= item_s1.data_byte;
				end
				gather_cnt_q <= gather_cnt_q + 1'b1;
			end
			if (gather_clr) begin
				gather_q     <= '0;
				gather_cnt_q <= '0;
			end
			if (bitpos_clr) begin
				bit_pos_q <= '0;
			end
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !q_full)
		else $error("job pushed into a full queue");

	a_pos_in_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !first_s1) |-> (pos_s1 <= 4'd8))
		else $error("unpack position past end of byte");

endmodule

// ===== design/ibb_back.sv =====
module ibb_back import ibb_pkg::*; #(
	parameter int PALETTE_DEPTH = PAL_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  job_t job,
	input  logic job_avail,
	output logic job_pop,
	output res_t result,
	output logic empty,
	input  logic pop
);

	localparam int PAL_AW = $clog2(PALETTE_DEPTH);

	logic [23:0] pal_mem [PALETTE_DEPTH];

	// Stage 2: palette data, key check, multiplier operands
	logic        valid_s2;
	logic        end_s2;
	logic        direct_s2;
	logic        oob_s2;
	logic [23:0] dcolor_s2;
	logic [23:0] rdata_s2;
	logic [23:0] a_s2;
	logic [12:0] m_s2;
	logic [23:0] add_s2;

	// Stage 3: result waiting until its last flag is known
	logic        valid_s3;
	logic        end_s3;
	logic [23:0] prod_s3;
	logic [23:0] add_s3;
	logic [23:0] color_s3;

	logic        in_range;
	logic        pop_wr;
	logic        pop_px;
	logic        s2_ok;
	logic [23:0] rx;
	logic [23:0] ry;
	logic [23:0] wid;
	logic [23:0] hgt;
	logic [23:0] a_nx;
	logic [12:0] m_nx;
	logic [23:0] add_nx;
	logic [23:0] color_s2;
	logic        emit_s2;
	logic [23:0] prod_w;
	logic        res_full;
	logic        res_push;
	res_t        res_in;

	assign in_range = {1'b0, job.index} < 9'(PALETTE_DEPTH);
	assign s2_ok    = !valid_s2 || !valid_s3 || !res_full;
	assign pop_wr   = job_avail && (job.kind == JOB_WRITE);
	assign pop_px   = job_avail && (job.kind == JOB_PIXEL) && s2_ok;
	assign job_pop  = pop_wr || pop_px;

	// Rotation: offset = a * m + add
	always_comb begin
		rx  = 24'(job.x) - 24'(cfg.fb_left);
		ry  = 24'(job.y) - 24'(cfg.fb_top);
		wid = 24'(cfg.fb_width);
		hgt = 24'(cfg.fb_height);
		unique case (cfg.orientation)
			ORIENT_0: begin
				a_nx   = ry;
				m_nx   = cfg.fb_width;
				add_nx = rx;
			end
			ORIENT_90: begin
				a_nx   = wid - rx - 24'd1;
				m_nx   = cfg.fb_height;
				add_nx = ry;
			end
			ORIENT_180: begin
				a_nx   = hgt - ry - 24'd1;
				m_nx   = cfg.fb_width;
				add_nx = wid - rx - 24'd1;
			end
			ORIENT_270: begin
				a_nx   = rx;
				m_nx   = cfg.fb_height;
				add_nx = hgt - ry - 24'd1;
			end
		endcase
	end

	// Palette memory: writes and reads in queue order
	always_ff @(posedge clk) begin
		if (pop_wr && in_range) begin
			pal_mem[job.index[PAL_AW-1:0]] <= job.color;
		end
		if (pop_px) begin
			rdata_s2 <= pal_mem[job.index[PAL_AW-1:0]];
		end
	end

	// Color select and key
	always_comb begin
		if (direct_s2) begin
			color_s2 = dcolor_s2;
		end else if (oob_s2) begin
			color_s2 = '0;
		end else begin
			color_s2 = rdata_s2;
		end
		emit_s2 = !(cfg.key_enable && (color_s2 == cfg.key_color));
		prod_w  = a_s2 * 24'(m_s2);
	end

	// A result leaves stage 3, when the result queue has room, once a later emitted pixel
	// or the end of its transaction is seen
	always_comb begin
		res_push = valid_s3 && !res_full &&
			(end_s3 || (valid_s2 && (emit_s2 || end_s2)));
		res_in.pixel_offset = prod_s3 + add_s3;
		res_in.color        = color_s3;
		res_in.last         = end_s3 || (valid_s2 && !emit_s2 && end_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s2_ok) begin
				valid_s2 <= pop_px;
			end
			if (s2_ok && valid_s2 && emit_s2) begin
				valid_s3 <= 1'b1;
			end else if (res_push) begin
				valid_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_px) begin
			end_s2    <= job.is_end;
			direct_s2 <= job.direct;
			oob_s2    <= !in_range;
			dcolor_s2 <= job.color;
			a_s2      <= a_nx;
			m_s2      <= m_nx;
			add_s2    <= add_nx;
		end
		if (s2_ok && valid_s2 && emit_s2) begin
			end_s3   <= end_s2;
			prod_s3  <= prod_w;
			add_s3   <= add_s2;
			color_s3 <= color_s2;
		end
	end

	// Result queue
	ibb_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_QUEUE_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

	a_s3_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_ok && valid_s2 && emit_s2 && valid_s3) |-> res_push)
		else $error("pending result overwritten");

	a_end_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && end_s3 && !res_full) |=> !(valid_s3 && end_s3 && $stable(prod_s3)
			&& $stable(add_s3) && $stable(color_s3) && !$past(valid_s2 && emit_s2)))
		else $error("final result of a transaction held back");

endmodule
